// File: design/srq_pkg.sv
// Shared types and codes for the sorted ring queue with binary search.
package srq_pkg;

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_MISS  = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} srq_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] position;
		logic [2:0] count;
	} srq_out_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} srq_cmp_t;

endpackage

// File: design/sorted_ring_queue_search.sv
// Top level: ring queue with push, pop and binary search over the held words.
// A transaction is taken when start is high and busy is low. Push, pop and unused
// codes give their result in the cycle after acceptance. A search of k probes runs
// S_PROBE then S_CMP for each probe and ends in a final S_PROBE on a miss, with k at
// most $clog2(DEPTH), since each probe reads one slot through the single registered
// read port and then runs through the one shared compare unit. The result is shown
// for exactly one cycle with done high and cannot be stalled.
module sorted_ring_queue_search #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  srq_pkg::srq_in_t  cmd,
	output logic              busy,
	output logic              done,
	output srq_pkg::srq_out_t result
);
	import srq_pkg::*;

	localparam int IW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_CMP   = 3'b100
	} state_t;

	state_t             state_q;
	logic [IW-1:0]      head_q, tail_q;
	logic [IW-1:0]      lo_q, hip_q, mid_q, slot_q;
	logic signed [31:0] key_q;
	logic               done_q;
	srq_out_t           result_q;

	logic               accept;
	logic [IW-1:0]      n, head_nx, tail_nx, mid, slot;
	logic [IW:0]        mid_sum, slot_sum;
	logic               full, push_we;
	logic signed [31:0] rdata;
	srq_cmp_t           cmp;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign n = (tail_q >= head_q) ? (tail_q - head_q)
	                              : IW'((IW+1)'(tail_q) + (IW+1)'(DEPTH) - (IW+1)'(head_q));
	assign full    = ((IW+1)'(n) == (IW+1)'(DEPTH - 1));
	assign head_nx = ((IW+1)'(head_q) + 1'b1 == (IW+1)'(DEPTH)) ? '0 : head_q + 1'b1;
	assign tail_nx = ((IW+1)'(tail_q) + 1'b1 == (IW+1)'(DEPTH)) ? '0 : tail_q + 1'b1;

	assign mid_sum  = (IW+1)'(lo_q) + (IW+1)'(hip_q) - 1'b1;
	assign mid      = IW'(mid_sum >> 1);
	assign slot_sum = (IW+1)'(head_q) + (IW+1)'(mid);
	assign slot     = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
	                                               : IW'(slot_sum);

	assign push_we = accept && (cmd.func == FUNC_PUSH) && !full;

	srq_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (push_we),
		.waddr (tail_q),
		.wdata (cmd.value),
		.raddr (slot),
		.rdata (rdata)
	);

	srq_cmp u_cmp (
		.a   (rdata),
		.b   (key_q),
		.res (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			lo_q     <= '0;
			hip_q    <= '0;
			mid_q    <= '0;
			slot_q   <= '0;
			key_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.func)
							FUNC_PUSH: begin
								done_q <= 1'b1;
								if (full) begin
									result_q <= '{STAT_FULL, 3'd0, 3'(n)};
								end else begin
									tail_q   <= tail_nx;
									result_q <= '{STAT_OK, 3'd0, 3'(n + 1'b1)};
								end
							end
							FUNC_POP: begin
								done_q <= 1'b1;
								if (n == '0) begin
									result_q <= '{STAT_EMPTY, 3'd0, 3'd0};
								end else begin
									head_q   <= head_nx;
									result_q <= '{STAT_OK, 3'd0, 3'(n - 1'b1)};
								end
							end
							FUNC_SEARCH: begin
								if (n == '0) begin
									done_q   <= 1'b1;
									result_q <= '{STAT_EMPTY, 3'd0, 3'd0};
								end else begin
									key_q   <= cmd.value;
									lo_q    <= '0;
									hip_q   <= n;
									state_q <= S_PROBE;
								end
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '{STAT_OK, 3'd0, 3'(n)};
							end
						endcase
					end
				end
				S_PROBE: begin
					if (lo_q < hip_q) begin
						mid_q   <= mid;
						slot_q  <= slot;
						state_q <= S_CMP;
					end else begin
						done_q   <= 1'b1;
						result_q <= '{STAT_MISS, 3'd0, 3'(n)};
						state_q  <= S_IDLE;
					end
				end
				S_CMP: begin
					if (cmp.eq) begin
						done_q   <= 1'b1;
						result_q <= '{STAT_OK, 3'(slot_q), 3'(n)};
						state_q  <= S_IDLE;
					end else begin
						if (cmp.lt) begin
							lo_q <= mid_q + 1'b1;
						end else begin
							hip_q <= mid_q;
						end
						state_q <= S_PROBE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer is busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("transaction accepted but neither finished nor in progress");

	a_pos_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != STAT_OK)) |-> (result.position == 3'd0))
		else $error("nonzero position on a failed transaction");
endmodule

// File: design/srq_ram.sv
// Slot storage: one write port, one registered read port.
module srq_ram #(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic signed [31:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic signed [31:0]       rdata
);
	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/srq_cmp.sv
// Shared signed compare unit used by every search probe.
module srq_cmp (
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output srq_pkg::srq_cmp_t  res
);
	import srq_pkg::*;

	assign res.eq = (a == b);
	assign res.lt = (a < b);
endmodule
